[rtl/core/hfpu_pkg.sv]
// Shared types and constants for the heading frame parser with unwrap.
`timescale 1ns / 1ps

package hfpu_pkg;

    // Resolution of one full turn of the raw heading.
    localparam int FULL_TURN = 5760;

    localparam logic [15:0] QUARTER     = 16'(FULL_TURN / 4);
    localparam logic [15:0] THREE_QUART = 16'((3 * FULL_TURN) / 4);
    localparam logic [31:0] TURN_STEP   = 32'(FULL_TURN);

    localparam logic [7:0] MARKER_RESET = 8'd187;

    // Frame length that carries a heading sample.
    localparam logic [7:0] SAMPLE_LEN = 8'd2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_SET  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LEN  = 2'd1,
        PH_RECV = 2'd2
    } t_phase;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_MARKER = 1'b0,
        REG_NONE   = 1'b1
    } t_reg;

    typedef struct packed {
        t_op                opcode;
        logic [7:0]         rx_byte;
        logic signed [31:0] set_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] heading;
        logic               sample_updated;
        logic               started;
    } t_out_beat;

endpackage

[rtl/core/hfpu_if.sv]
// Valid/ready channel interfaces for input bytes and heading results.
`timescale 1ns / 1ps

interface hfpu_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         rx_byte;
    logic signed [31:0] set_value;

    modport source (output valid, output opcode, output rx_byte, output set_value,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input set_value,
                    output ready);
endinterface

interface hfpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] heading;
    logic               sample_updated;
    logic               started;

    modport source (output valid, output heading, output sample_updated,
                    output started, input ready);
    modport sink   (input valid, input heading, input sample_updated,
                    input started, output ready);
endinterface

[rtl/core/hfpu_parser.sv]
// Frame parser state, raw heading tracking and zero-offset unwrap.
`timescale 1ns / 1ps

module hfpu_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  hfpu_pkg::t_in_beat   i_beat,
    input  logic [7:0]           i_marker,
    output hfpu_pkg::t_out_beat  o_result
);

    hfpu_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_len,  n_len;
    logic [7:0]  r_idx,  n_idx;
    logic [7:0]  r_low,  n_low;
    logic [7:0]  r_high, n_high;
    logic [15:0] r_raw,  n_raw;
    logic [31:0] r_zero, n_zero;
    logic        r_seen, n_seen;

    logic [7:0]  idx_inc;
    logic [15:0] sample;
    logic        updated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hfpu_pkg::PH_WAIT;
            r_len   <= '0;
            r_idx   <= '0;
            r_low   <= '0;
            r_high  <= '0;
            r_raw   <= '0;
            r_zero  <= '0;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_low   <= n_low;
            r_high  <= n_high;
            r_raw   <= n_raw;
            r_zero  <= n_zero;
            r_seen  <= n_seen;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_low   = r_low;
        n_high  = r_high;
        n_raw   = r_raw;
        n_zero  = r_zero;
        n_seen  = r_seen;
        updated = 1'b0;
        idx_inc = r_idx + 8'd1;
        sample  = '0;

        if (i_beat.opcode == hfpu_pkg::OP_SET) begin
            n_zero = {16'd0, r_raw} - 32'(i_beat.set_value);
        end else begin
            unique case (r_phase)
                hfpu_pkg::PH_LEN: begin
                    n_len   = i_beat.rx_byte;
                    n_idx   = '0;
                    n_phase = hfpu_pkg::PH_RECV;
                end
                hfpu_pkg::PH_RECV: begin
                    // keep only the first two payload bytes
                    if (r_idx == 8'd0) begin
                        n_low = i_beat.rx_byte;
                    end else if (r_idx == 8'd1) begin
                        n_high = i_beat.rx_byte;
                    end
                    n_idx  = idx_inc;
                    sample = {n_high, n_low};
                    if (idx_inc == r_len) begin
                        n_phase = hfpu_pkg::PH_WAIT;
                        if (r_len == hfpu_pkg::SAMPLE_LEN) begin
                            // shift the zero when the raw value crosses the wrap point
                            if (r_raw > hfpu_pkg::THREE_QUART
                                && sample < hfpu_pkg::QUARTER) begin
                                n_zero = r_zero - hfpu_pkg::TURN_STEP;
                            end else if (r_raw < hfpu_pkg::QUARTER
                                && sample > hfpu_pkg::THREE_QUART) begin
                                n_zero = r_zero + hfpu_pkg::TURN_STEP;
                            end
                            n_raw   = sample;
                            n_seen  = 1'b1;
                            updated = 1'b1;
                        end
                    end
                end
                default: begin
                    // waiting for marker; the unused code behaves the same
                    if (i_beat.rx_byte == i_marker) begin
                        n_phase = hfpu_pkg::PH_LEN;
                    end else begin
                        n_phase = hfpu_pkg::PH_WAIT;
                    end
                end
            endcase
        end

        o_result.heading        = $signed({16'd0, n_raw} - n_zero);
        o_result.sample_updated = updated;
        o_result.started        = n_seen;
    end

    a_sample_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.sample_updated |=> r_phase == hfpu_pkg::PH_WAIT && r_seen)
        else $error("sample did not close the frame");

    a_set_keeps_parser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_beat.opcode == hfpu_pkg::OP_SET |=>
        $stable(r_phase) && $stable(r_idx) && $stable(r_raw))
        else $error("set command disturbed parser state");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("started flag dropped");

endmodule

[rtl/core/heading_frame_parser_unwrap.sv]
// Top level: input stage, parser, result register and configuration port.
//
//   channel   dir   handshake        payload
//   i_in      in    valid/ready      opcode, rx_byte, set_value
//   o_out     out   valid/ready      heading, sample_updated, started
//   apb       in    psel/penable     response_marker at address 0
//
// Each beat is held in the input register, then passes through the parser
// into the result register. One beat is accepted per cycle while results are
// taken. Parser state updates as a beat leaves the input register. A stall on
// o_out holds both stages; the input register takes a beat during the stall
// only while it is empty. Reset is synchronous and returns the marker to its
// default.
`timescale 1ns / 1ps

module heading_frame_parser_unwrap (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    hfpu_in_if.sink                              i_in,
    hfpu_out_if.source                           o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hfpu_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hfpu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hfpu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic                 r_in_valid;
    hfpu_pkg::t_in_beat   r_in;
    logic                 r_out_valid;
    hfpu_pkg::t_out_beat  r_out;
    hfpu_pkg::t_out_beat  result;
    logic [7:0]           r_marker;
    logic                 step;
    hfpu_pkg::t_reg       reg_sel;

    // advance when the result register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.opcode    <= hfpu_pkg::t_op'(i_in.opcode);
            r_in.rx_byte   <= i_in.rx_byte;
            r_in.set_value <= i_in.set_value;
        end
    end

    hfpu_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in),
        .i_marker (r_marker),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.heading        = r_out.heading;
    assign o_out.sample_updated = r_out.sample_updated;
    assign o_out.started        = r_out.started;

    // configuration registers sit on 32-bit word addresses
    assign reg_sel = hfpu_pkg::t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= hfpu_pkg::MARKER_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_sel == hfpu_pkg::REG_MARKER) begin
            r_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            hfpu_pkg::REG_MARKER: prdata = {{(hfpu_pkg::APB_DATA_W-8){1'b0}}, r_marker};
            default:              prdata = '0;
        endcase
    end

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result lost after parser step");

    a_empty_takes_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("empty input stage refused a beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !step)
        else $error("stalled result overwritten");

endmodule
